FILE: sv/bcpr_pkg.sv
// shared constants and register codes for the box corner projection block
`default_nettype none
package bcpr_pkg;

  // default for the largest image dimension the block handles
  localparam int unsigned MAX_IMAGE_DIM_DEF = 4096;

  // fractional bits of the focal and center registers
  localparam int unsigned FRAC_BITS = 12;
  // shift that gives one half pixel in the scaled numerator
  localparam int unsigned HALF_SHIFT = FRAC_BITS - 1;

  // corners needed for a rectangle
  localparam int unsigned MIN_CORNERS = 2;

  // widths fixed by the interface
  localparam int unsigned COORD_W = 32;
  localparam int unsigned PARAM_W = 24;
  localparam int unsigned DIM_W   = 13;
  localparam int unsigned OUT_W   = 12;
  localparam int unsigned CFG_A_W = 3;
  localparam int unsigned CFG_D_W = 24;

  // working width of numerators, limits and remainders
  localparam int unsigned ACC_W = 64;

  // projection lanes: two axes times two coordinates times two depths
  localparam int unsigned LANES   = 8;
  localparam int unsigned CORNERS = 8;

  typedef enum logic [CFG_A_W-1:0] {
    CFG_FOCAL_X  = 3'd0,
    CFG_FOCAL_Y  = 3'd1,
    CFG_CENTER_X = 3'd2,
    CFG_CENTER_Y = 3'd3,
    CFG_IMAGE_W  = 3'd4,
    CFG_IMAGE_H  = 3'd5
  } cfg_reg_e;

endpackage
`default_nettype wire

FILE: sv/box_corner_projection_to_rect.sv
// top level: pipelined pinhole projection of a 3d box to an image rectangle
//
//  channel   signals                                  direction  transfer when
//  box in    start_i, busy_o, box_{min,max}_{x,y,z}_i  in        start_i high, busy_o low
//  result    done_o, rect_valid_o, rect_{left,top,     out       done_o high (one cycle)
//            right,bottom}_o
//  config    cfg_we_i, cfg_addr_i, cfg_wdata_i        in        cfg_we_i high
//
// one box enters every cycle; busy_o stays low, the pipe never stalls
// stages: multiply, add and range check, one restoring divider stage per
// quotient bit, a three-level min/max tree and the output register
// reset clears the config registers and the done valid chain, not the data or ok flags
// the receiver cannot stall, so each result is shown for exactly one cycle
`default_nettype none
module box_corner_projection_to_rect #(
  parameter int unsigned MAX_IMAGE_DIM = bcpr_pkg::MAX_IMAGE_DIM_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // box in
  input  wire logic                              start_i,
  output      logic                              busy_o,
  input  wire logic signed [bcpr_pkg::COORD_W-1:0] box_min_x_i,
  input  wire logic signed [bcpr_pkg::COORD_W-1:0] box_min_y_i,
  input  wire logic signed [bcpr_pkg::COORD_W-1:0] box_min_z_i,
  input  wire logic signed [bcpr_pkg::COORD_W-1:0] box_max_x_i,
  input  wire logic signed [bcpr_pkg::COORD_W-1:0] box_max_y_i,
  input  wire logic signed [bcpr_pkg::COORD_W-1:0] box_max_z_i,
  // config
  input  wire logic                              cfg_we_i,
  input  wire logic [bcpr_pkg::CFG_A_W-1:0]      cfg_addr_i,
  input  wire logic [bcpr_pkg::CFG_D_W-1:0]      cfg_wdata_i,
  // result
  output      logic                              done_o,
  output      logic                              rect_valid_o,
  output      logic [bcpr_pkg::OUT_W-1:0]        rect_left_o,
  output      logic [bcpr_pkg::OUT_W-1:0]        rect_top_o,
  output      logic [bcpr_pkg::OUT_W-1:0]        rect_right_o,
  output      logic [bcpr_pkg::OUT_W-1:0]        rect_bottom_o
);

  // pixel width; a quotient never exceeds the saturated dimension
  localparam int unsigned PW  = $clog2(MAX_IMAGE_DIM + 1);
  localparam int unsigned LAT = PW + 7;
  localparam int unsigned AW  = bcpr_pkg::ACC_W;
  localparam int unsigned NL  = bcpr_pkg::LANES;

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic [bcpr_pkg::PARAM_W-1:0] focal_x_q, focal_y_q, center_x_q, center_y_q;
  logic [bcpr_pkg::DIM_W-1:0]   image_w_q, image_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q  <= '0;
      focal_y_q  <= '0;
      center_x_q <= '0;
      center_y_q <= '0;
      image_w_q  <= '0;
      image_h_q  <= '0;
    end else if (cfg_we_i) begin
      case (bcpr_pkg::cfg_reg_e'(cfg_addr_i))
        bcpr_pkg::CFG_FOCAL_X:  focal_x_q  <= cfg_wdata_i;
        bcpr_pkg::CFG_FOCAL_Y:  focal_y_q  <= cfg_wdata_i;
        bcpr_pkg::CFG_CENTER_X: center_x_q <= cfg_wdata_i;
        bcpr_pkg::CFG_CENTER_Y: center_y_q <= cfg_wdata_i;
        bcpr_pkg::CFG_IMAGE_W:  image_w_q  <= cfg_wdata_i[bcpr_pkg::DIM_W-1:0];
        bcpr_pkg::CFG_IMAGE_H:  image_h_q  <= cfg_wdata_i[bcpr_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // dimensions saturated to the largest supported size
  logic [PW-1:0] w_sat, h_sat;
  assign w_sat = (32'(image_w_q) > 32'(MAX_IMAGE_DIM)) ? PW'(MAX_IMAGE_DIM)
                                                       : PW'(image_w_q);
  assign h_sat = (32'(image_h_q) > 32'(MAX_IMAGE_DIM)) ? PW'(MAX_IMAGE_DIM)
                                                       : PW'(image_h_q);

  // any zero focal length or dimension kills every result
  logic cfg_dead;
  assign cfg_dead = (w_sat == '0) || (h_sat == '0) ||
                    (focal_x_q == '0) || (focal_y_q == '0);

  // ---------------------------------------------------------------------
  // valid bits travelling with the data
  // ---------------------------------------------------------------------
  logic           start_acc;
  logic [LAT:1]   vld_q;

  assign busy_o    = 1'b0;
  assign start_acc = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-1:1], start_acc};
    end
  end

  // ---------------------------------------------------------------------
  // lanes: bit 2 picks the axis, bit 1 the coordinate, bit 0 the depth
  // ---------------------------------------------------------------------
  logic signed [AW-1:0] pf_q   [NL];  // focal * coordinate
  logic signed [AW-1:0] pc_q   [NL];  // center * depth
  logic signed [AW-1:0] lim1_q [NL];  // dim * depth, scaled
  logic signed [AW-1:0] z1_q   [NL];
  logic signed [AW-1:0] num_q  [NL];
  logic signed [AW-1:0] lim2_q [NL];
  logic signed [AW-1:0] z2_q   [NL];

  // divider pipe, index 0 is loaded by the range check stage
  logic [AW-1:0] rem_q [PW+1][NL];
  logic [AW-1:0] dv_q  [PW+1][NL];
  logic [PW-1:0] qt_q  [PW+1][NL];
  logic          okd_q [PW+1][NL];

  for (genvar g = 0; g < NL; g++) begin : g_lane
    localparam bit AXIS_Y = ((g >> 2) & 1) != 0;
    localparam bit HI_C   = ((g >> 1) & 1) != 0;
    localparam bit HI_Z   = (g & 1) != 0;

    logic signed [bcpr_pkg::COORD_W-1:0] crd, zc;
    logic [bcpr_pkg::PARAM_W-1:0]        fl, ce;
    logic [PW-1:0]                       dim;
    logic signed [bcpr_pkg::PARAM_W+bcpr_pkg::COORD_W:0] pf, pc;
    logic signed [PW+bcpr_pkg::COORD_W:0]                pl;
    logic                                zpos;
    logic                                in_rng;

    assign crd = AXIS_Y ? (HI_C ? box_max_y_i : box_min_y_i)
                        : (HI_C ? box_max_x_i : box_min_x_i);
    assign zc  = HI_Z ? box_max_z_i : box_min_z_i;
    assign fl  = AXIS_Y ? focal_y_q  : focal_x_q;
    assign ce  = AXIS_Y ? center_y_q : center_x_q;
    assign dim = AXIS_Y ? h_sat : w_sat;

    assign pf = $signed({1'b0, fl}) * crd;
    assign pc = $signed({1'b0, ce}) * zc;
    assign pl = $signed({1'b0, dim}) * zc;

    // stage 1: products
    always_ff @(posedge clk_i) begin
      pf_q[g]   <= AW'(pf);
      pc_q[g]   <= AW'(pc);
      lim1_q[g] <= AW'(pl) <<< bcpr_pkg::FRAC_BITS;
      z1_q[g]   <= AW'(zc);
    end

    // stage 2: numerator
    always_ff @(posedge clk_i) begin
      num_q[g]  <= pf_q[g] + pc_q[g];
      lim2_q[g] <= lim1_q[g];
      z2_q[g]   <= z1_q[g];
    end

    // stage 3: range check on the exact value, add the half pixel
    assign zpos   = (z2_q[g] > 0);
    assign in_rng = !num_q[g][AW-1] && (num_q[g] < lim2_q[g]);

    always_ff @(posedge clk_i) begin
      okd_q[0][g] <= zpos && in_rng;
      rem_q[0][g] <= AW'(num_q[g] + (z2_q[g] <<< bcpr_pkg::HALF_SHIFT));
      dv_q[0][g]  <= AW'(z2_q[g] <<< bcpr_pkg::FRAC_BITS);
      qt_q[0][g]  <= '0;
    end

    // restoring divider, one quotient bit per stage
    for (genvar s = 0; s < PW; s++) begin : g_div
      localparam int unsigned B = PW - 1 - s;
      logic [AW-1:0] sh;
      logic          ge;

      assign sh = dv_q[s][g] << B;
      assign ge = (rem_q[s][g] >= sh);

      always_ff @(posedge clk_i) begin
        rem_q[s+1][g] <= ge ? (rem_q[s][g] - sh) : rem_q[s][g];
        qt_q[s+1][g]  <= qt_q[s][g] | (PW'(ge) << B);
        dv_q[s+1][g]  <= dv_q[s][g];
        okd_q[s+1][g] <= okd_q[s][g];
      end
    end
  end

  // ---------------------------------------------------------------------
  // corners and the min/max tree
  // ---------------------------------------------------------------------
  logic          t_ok   [4][bcpr_pkg::CORNERS];
  logic [PW-1:0] t_minu [4][bcpr_pkg::CORNERS];
  logic [PW-1:0] t_maxu [4][bcpr_pkg::CORNERS];
  logic [PW-1:0] t_minv [4][bcpr_pkg::CORNERS];
  logic [PW-1:0] t_maxv [4][bcpr_pkg::CORNERS];
  logic [bcpr_pkg::CORNERS-1:0] c_ok;
  logic          enough_q [1:3];

  for (genvar c = 0; c < bcpr_pkg::CORNERS; c++) begin : g_corner
    // corner picks x coordinate, y coordinate and depth
    localparam int unsigned XL = ((c >> 2) & 1) * 2 + (c & 1);
    localparam int unsigned YL = 4 + ((c >> 1) & 1) * 2 + (c & 1);

    assign c_ok[c]      = okd_q[PW][XL] && okd_q[PW][YL];
    assign t_ok[0][c]   = c_ok[c];
    assign t_minu[0][c] = qt_q[PW][XL];
    assign t_maxu[0][c] = qt_q[PW][XL];
    assign t_minv[0][c] = qt_q[PW][YL];
    assign t_maxv[0][c] = qt_q[PW][YL];
  end

  always_ff @(posedge clk_i) begin
    enough_q[1] <= ($countones(c_ok) >= bcpr_pkg::MIN_CORNERS);
    enough_q[2] <= enough_q[1];
    enough_q[3] <= enough_q[2];
  end

  for (genvar lv = 1; lv < 4; lv++) begin : g_lvl
    for (genvar e = 0; e < (bcpr_pkg::CORNERS >> lv); e++) begin : g_node
      logic a_ok, b_ok;
      assign a_ok = t_ok[lv-1][2*e];
      assign b_ok = t_ok[lv-1][2*e+1];

      always_ff @(posedge clk_i) begin
        t_ok[lv][e] <= a_ok || b_ok;
        t_minu[lv][e] <= (a_ok && (!b_ok || t_minu[lv-1][2*e] <= t_minu[lv-1][2*e+1]))
                         ? t_minu[lv-1][2*e] : t_minu[lv-1][2*e+1];
        t_maxu[lv][e] <= (a_ok && (!b_ok || t_maxu[lv-1][2*e] >= t_maxu[lv-1][2*e+1]))
                         ? t_maxu[lv-1][2*e] : t_maxu[lv-1][2*e+1];
        t_minv[lv][e] <= (a_ok && (!b_ok || t_minv[lv-1][2*e] <= t_minv[lv-1][2*e+1]))
                         ? t_minv[lv-1][2*e] : t_minv[lv-1][2*e+1];
        t_maxv[lv][e] <= (a_ok && (!b_ok || t_maxv[lv-1][2*e] >= t_maxv[lv-1][2*e+1]))
                         ? t_maxv[lv-1][2*e] : t_maxv[lv-1][2*e+1];
      end
    end

    // entries past the nodes of each level are unused
    for (genvar e = (bcpr_pkg::CORNERS >> lv); e < bcpr_pkg::CORNERS; e++) begin : g_pad
      assign t_ok[lv][e]   = 1'b0;
      assign t_minu[lv][e] = '0;
      assign t_maxu[lv][e] = '0;
      assign t_minv[lv][e] = '0;
      assign t_maxv[lv][e] = '0;
    end
  end

  // ---------------------------------------------------------------------
  // clamp, emptiness check and output register
  // ---------------------------------------------------------------------
  function automatic logic [bcpr_pkg::OUT_W-1:0] lo_bits(input logic [PW-1:0] p);
    logic [31:0] e;
    e = 32'(p);
    return e[bcpr_pkg::OUT_W-1:0];
  endfunction

  logic [PW-1:0] wm1, hm1, cl_l, cl_r, cl_t, cl_b;
  logic          fin_ok;

  assign wm1  = w_sat - PW'(1);
  assign hm1  = h_sat - PW'(1);
  assign cl_l = (t_minu[3][0] > wm1) ? wm1 : t_minu[3][0];
  assign cl_r = (t_maxu[3][0] > wm1) ? wm1 : t_maxu[3][0];
  assign cl_t = (t_minv[3][0] > hm1) ? hm1 : t_minv[3][0];
  assign cl_b = (t_maxv[3][0] > hm1) ? hm1 : t_maxv[3][0];

  assign fin_ok = enough_q[3] && !cfg_dead && (cl_r > cl_l) && (cl_b > cl_t);

  logic                      rect_valid_q;
  logic [bcpr_pkg::OUT_W-1:0] rect_left_q, rect_top_q, rect_right_q, rect_bottom_q;

  always_ff @(posedge clk_i) begin
    rect_valid_q  <= fin_ok;
    rect_left_q   <= fin_ok ? lo_bits(cl_l) : '0;
    rect_top_q    <= fin_ok ? lo_bits(cl_t) : '0;
    rect_right_q  <= fin_ok ? lo_bits(cl_r) : '0;
    rect_bottom_q <= fin_ok ? lo_bits(cl_b) : '0;
  end

  assign done_o        = vld_q[LAT];
  assign rect_valid_o  = rect_valid_q;
  assign rect_left_o   = rect_left_q;
  assign rect_top_o    = rect_top_q;
  assign rect_right_o  = rect_right_q;
  assign rect_bottom_o = rect_bottom_q;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  a_fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_acc, LAT))
    else $error("result without a box transfer at fixed latency");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !rect_valid_o) |-> (rect_left_o == '0 && rect_top_o == '0 &&
                                   rect_right_o == '0 && rect_bottom_o == '0))
    else $error("invalid result with nonzero fields");

  a_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rect_valid_o) |-> (rect_right_o > rect_left_o &&
                                  rect_bottom_o > rect_top_o))
    else $error("valid result with empty rectangle");

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
// testbench for the box corner projection block: directed and random boxes, self-checking
`timescale 1ns / 100ps
module testbench;

  localparam int unsigned LATENCY = 20;   // result latency of the block at the default maximum dimension
  localparam int unsigned WATCHDOG = 4000; // cycles without any transfer
  localparam int unsigned NUM_RANDOM = 1200;

  typedef struct {
    logic signed [bcpr_pkg::COORD_W-1:0] x0, y0, z0, x1, y1, z1;
  } box_t;

  typedef struct {
    logic                       valid;
    logic [bcpr_pkg::OUT_W-1:0] left, top, right, bottom;
  } rect_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic signed [bcpr_pkg::COORD_W-1:0] box_min_x_i = '0, box_min_y_i = '0, box_min_z_i = '0;
  logic signed [bcpr_pkg::COORD_W-1:0] box_max_x_i = '0, box_max_y_i = '0, box_max_z_i = '0;
  logic                         cfg_we_i = 1'b0;
  logic [bcpr_pkg::CFG_A_W-1:0] cfg_addr_i = '0;
  logic [bcpr_pkg::CFG_D_W-1:0] cfg_wdata_i = '0;
  logic                         done_o, rect_valid_o;
  logic [bcpr_pkg::OUT_W-1:0]   rect_left_o, rect_top_o, rect_right_o, rect_bottom_o;

  // mirror of the config registers as the predictor sees them
  logic [bcpr_pkg::PARAM_W-1:0] focal_x, focal_y, center_x, center_y;
  logic [bcpr_pkg::DIM_W-1:0]   img_w, img_h;

  rect_t expected_rects[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  bit          box_taken = 1'b0;
  bit          no_gaps = 1'b0;

  always #10 clk_i = ~clk_i;

  box_corner_projection_to_rect uut (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .box_min_x_i, .box_min_y_i, .box_min_z_i,
    .box_max_x_i, .box_max_y_i, .box_max_z_i,
    .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .done_o, .rect_valid_o, .rect_left_o, .rect_top_o, .rect_right_o, .rect_bottom_o
  );

  // one axis of the pinhole model; 0 when the exact value is off the image
  function automatic bit project_axis(longint f, longint c, longint coord, longint z,
                                      longint dim, output longint pix);
    longint num, lim;
    num = f * coord + c * z;
    lim = dim * 4096 * z;
    pix = 0;
    if (num < 0 || num >= lim) return 1'b0;
    pix = (num + 2048 * z) / (4096 * z);
    return 1'b1;
  endfunction

  function automatic rect_t project_box(box_t b);
    rect_t  r;
    longint xs[2], ys[2], zs[2];
    longint w, h, pu, pv, minx, maxx, miny, maxy;
    int     corners;
    r = '{1'b0, '0, '0, '0, '0};
    xs[0] = b.x0; xs[1] = b.x1;
    ys[0] = b.y0; ys[1] = b.y1;
    zs[0] = b.z0; zs[1] = b.z1;
    // dimensions above the maximum saturate
    w = (img_w > 4096) ? 4096 : img_w;
    h = (img_h > 4096) ? 4096 : img_h;
    corners = 0;
    minx = 0; maxx = 0; miny = 0; maxy = 0;
    if (w == 0 || h == 0 || focal_x == 0 || focal_y == 0) return r;
    for (int i = 0; i < 8; i++) begin
      if (zs[i & 1] <= 0) continue;
      if (!project_axis(focal_x, center_x, xs[(i >> 2) & 1], zs[i & 1], w, pu)) continue;
      if (!project_axis(focal_y, center_y, ys[(i >> 1) & 1], zs[i & 1], h, pv)) continue;
      if (corners == 0) begin
        minx = pu; maxx = pu; miny = pv; maxy = pv;
      end else begin
        if (pu < minx) minx = pu;
        if (pu > maxx) maxx = pu;
        if (pv < miny) miny = pv;
        if (pv > maxy) maxy = pv;
      end
      corners++;
    end
    if (corners < bcpr_pkg::MIN_CORNERS) return r;
    // rounding can push a pixel onto the dimension itself
    if (minx > w - 1) minx = w - 1;
    if (maxx > w - 1) maxx = w - 1;
    if (miny > h - 1) miny = h - 1;
    if (maxy > h - 1) maxy = h - 1;
    if (maxx <= minx || maxy <= miny) return r;
    r.valid = 1'b1;
    r.left = minx[bcpr_pkg::OUT_W-1:0];
    r.top = miny[bcpr_pkg::OUT_W-1:0];
    r.right = maxx[bcpr_pkg::OUT_W-1:0];
    r.bottom = maxy[bcpr_pkg::OUT_W-1:0];
    return r;
  endfunction

  // result checker, sampled mid-cycle so it never races the edge
  always @(negedge clk_i) begin
    rect_t want;
    if (rst_ni && done_o) begin
      if (expected_rects.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer at %0t", $realtime);
      end else begin
        want = expected_rects.pop_front();
        if (rect_valid_o !== want.valid || rect_left_o !== want.left ||
            rect_top_o !== want.top || rect_right_o !== want.right ||
            rect_bottom_o !== want.bottom) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch at %0t: expected v=%0d l=%0d t=%0d r=%0d b=%0d,",
                      " got v=%0d l=%0d t=%0d r=%0d b=%0d"},
                     $realtime, want.valid, want.left, want.top, want.right, want.bottom,
                     rect_valid_o, rect_left_o, rect_top_o, rect_right_o, rect_bottom_o);
        end
      end
    end
  end

  // watchdog: any transfer on either side resets the count
  always @(negedge clk_i) begin
    if (box_taken || done_o) idle_cycles = 0;
    else idle_cycles++;
    box_taken = 1'b0;
    if (idle_cycles >= WATCHDOG) begin
      $display("status: fail");
      $finish;
    end
  end

  // writes all six registers back to back; caller sits at a rising edge
  task automatic write_config(int unsigned fx, int unsigned fy, int unsigned cx,
                              int unsigned cy, int unsigned w, int unsigned h);
    bcpr_pkg::cfg_reg_e regs[6];
    int unsigned        vals[6];
    regs = '{bcpr_pkg::CFG_FOCAL_X, bcpr_pkg::CFG_FOCAL_Y, bcpr_pkg::CFG_CENTER_X,
             bcpr_pkg::CFG_CENTER_Y, bcpr_pkg::CFG_IMAGE_W, bcpr_pkg::CFG_IMAGE_H};
    vals = '{fx, fy, cx, cy, w, h};
    for (int i = 0; i < 6; i++) begin
      cfg_we_i <= 1'b1;
      cfg_addr_i <= regs[i];
      cfg_wdata_i <= vals[i][bcpr_pkg::CFG_D_W-1:0];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    focal_x = fx[bcpr_pkg::PARAM_W-1:0];
    focal_y = fy[bcpr_pkg::PARAM_W-1:0];
    center_x = cx[bcpr_pkg::PARAM_W-1:0];
    center_y = cy[bcpr_pkg::PARAM_W-1:0];
    img_w = w[bcpr_pkg::DIM_W-1:0];
    img_h = h[bcpr_pkg::DIM_W-1:0];
    @(posedge clk_i);
  endtask

  // mostly short gaps, some long ones, none during a burst stretch
  task automatic idle_gap();
    int unsigned r, n;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) n = 0;
    else if (r < 92) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 40);
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // one box transfer, followed by a random idle gap
  task automatic send_box(box_t b);
    start_i <= 1'b1;
    box_min_x_i <= b.x0; box_min_y_i <= b.y0; box_min_z_i <= b.z0;
    box_max_x_i <= b.x1; box_max_y_i <= b.y1; box_max_z_i <= b.z1;
    forever begin
      @(negedge clk_i);
      if (!busy_o) break;
      @(posedge clk_i);
    end
    @(posedge clk_i);
    box_taken = 1'b1;
    expected_rects.insert(expected_rects.size(), project_box(b));
    idle_gap();
  endtask

  // wait for every result, then let the pipe run empty
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (expected_rects.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  function automatic box_t make_box(int x0, int y0, int z0, int x1, int y1, int z1);
    box_t b;
    b.x0 = x0; b.y0 = y0; b.z0 = z0; b.x1 = x1; b.y1 = y1; b.z1 = z1;
    return b;
  endfunction

  // plausible box in front of the camera, corners swapped now and then
  function automatic box_t scene_box();
    box_t b;
    int   z0, x0, y0;
    z0 = $urandom_range(32'h0000_4000, 32'h0020_0000);
    x0 = $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
    y0 = $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
    b.z0 = z0; b.x0 = x0; b.y0 = y0;
    b.z1 = z0 + $urandom_range(0, 32'h0004_0000);
    b.x1 = x0 + $urandom_range(0, 32'h0004_0000);
    b.y1 = y0 + $urandom_range(0, 32'h0004_0000);
    // a few boxes straddle the camera plane
    if ($urandom_range(0, 9) == 0) b.z0 = -$signed($urandom_range(0, 32'h0002_0000));
    if ($urandom_range(0, 3) == 0) begin
      b = make_box(b.x1, b.y1, b.z1, b.x0, b.y0, b.z0);
    end
    return b;
  endfunction

  function automatic box_t noise_box();
    return make_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  // every result is invalid while the registers hold their reset values
  task automatic test_reset_values();
    send_box(make_box(0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000));
    send_box(scene_box());
    drain();
  endtask

  task automatic test_directed();
    write_config(500 << 12, 500 << 12, 320 << 12, 240 << 12, 640, 480);
    // typical box, then the same box with corners swapped
    send_box(make_box(-32'sh0001_0000, -32'sh0001_0000, 32'h0004_0000,
                      32'h0001_0000, 32'h0001_0000, 32'h0006_0000));
    send_box(make_box(32'h0001_0000, 32'h0001_0000, 32'h0006_0000,
                      -32'sh0001_0000, -32'sh0001_0000, 32'h0004_0000));
    // one depth zero, one negative, both behind
    send_box(make_box(-32'sh0001_0000, -32'sh0001_0000, 0,
                      32'h0001_0000, 32'h0001_0000, 32'h0004_0000));
    send_box(make_box(-32'sh0001_0000, -32'sh0001_0000, -32'sh0004_0000,
                      32'h0001_0000, 32'h0001_0000, 32'h0004_0000));
    send_box(make_box(0, 0, -32'sh0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h8000_0000));
    // degenerate box: all corners on one pixel column, rectangle empty
    send_box(make_box(0, -32'sh0001_0000, 32'h0004_0000, 0, 32'h0001_0000, 32'h0004_0000));
    // only one corner inside the image
    send_box(make_box(32'h0000_2000, 32'h0000_2000, 32'h0004_0000,
                      32'h0010_0000, 32'h0010_0000, 32'h0004_0000));
    // right edge just inside: u = 639.9 rounds to 640 and is clamped
    send_box(make_box(32'h0000_0000, 0, 32'h0001_0000,
                      32'h0000_A3CA, 32'h0000_8000, 32'h0001_0000));
    // field extremes
    send_box(make_box(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_box(make_box(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 1, 32'h7FFF_FFFF));
    send_box(make_box(0, 0, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000));
    drain();
  endtask

  task automatic test_zero_focal();
    write_config(0, 500 << 12, 320 << 12, 240 << 12, 640, 480);
    send_box(scene_box());
    send_box(scene_box());
    drain();
    write_config(500 << 12, 0, 320 << 12, 240 << 12, 640, 480);
    send_box(scene_box());
    drain();
  endtask

  task automatic test_image_size();
    write_config(500 << 12, 500 << 12, 320 << 12, 240 << 12, 0, 480);
    send_box(scene_box());
    drain();
    write_config(500 << 12, 500 << 12, 320 << 12, 240 << 12, 640, 0);
    send_box(scene_box());
    drain();
    // oversized dimensions saturate, maximum registers everywhere
    write_config(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 13'h1FFF, 4097);
    for (int i = 0; i < 4; i++) send_box(scene_box());
    drain();
    // smallest image: any rectangle is empty
    write_config(1 << 12, 1 << 12, 0, 0, 1, 1);
    send_box(scene_box());
    drain();
  endtask

  task automatic test_random();
    int unsigned w, h;
    for (int phase = 0; phase < 8; phase++) begin
      w = (phase == 0) ? 4096 : $urandom_range(16, 4096);
      h = (phase == 0) ? 4096 : $urandom_range(16, 4096);
      write_config($urandom_range(50 << 12, 3000 << 12), $urandom_range(50 << 12, 3000 << 12),
                   $urandom_range(0, w << 12), $urandom_range(0, h << 12), w, h);
      for (int i = 0; i < NUM_RANDOM / 8; i++) begin
        if (i % 50 == 0) no_gaps = ($urandom_range(0, 2) == 0);
        if ($urandom_range(0, 3) == 0) send_box(noise_box());
        else send_box(scene_box());
      end
      no_gaps = 1'b0;
      drain();
    end
  endtask

  initial begin
    focal_x = '0; focal_y = '0; center_x = '0; center_y = '0; img_w = '0; img_h = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_directed();
    test_zero_focal();
    test_image_size();
    test_random();
    if (mismatches == 0 && expected_rects.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
